>>> rtl/spmdb_pkg.sv
// ----------------------------------------------------------------------------
// spmdb_pkg
// Shared types and constants of the stereo peak meter with dB output
// ----------------------------------------------------------------------------
package spmdb_pkg;

  localparam int SAMPLE_BITS = 24;

  localparam int LOG_FRAC = 24;
  localparam int MSB_W = $clog2(SAMPLE_BITS);
  localparam int NORM_W = 32;
  localparam int SHIFT_W = $clog2(NORM_W);
  localparam int NEG_LOG_W = MSB_W + LOG_FRAC;
  localparam int DB_K_W = 31;
  localparam logic [DB_K_W-1:0] DB_PER_LOG2_Q24 = 31'd1616142483;
  localparam int PROD_W = NEG_LOG_W + DB_K_W;
  localparam int R_W = PROD_W + 1 - 2 * LOG_FRAC;

  localparam int DB_W = 10;
  localparam int DB_FLOOR = 480;
  localparam logic signed [DB_W-1:0] DB_MIN = DB_W'(-DB_FLOOR);

  localparam int LANES = 4;
  localparam int LANE_SHORT_L = 0;
  localparam int LANE_SHORT_R = 1;
  localparam int LANE_LONG_L = 2;
  localparam int LANE_LONG_R = 3;

  localparam int ST_NORM = 1;
  localparam int ST_PROD = LOG_FRAC + 2;
  localparam int ST_OUT = LOG_FRAC + 3;
  localparam int PIPE_STAGES = LOG_FRAC + 4;

  localparam int LEN_W = 16;
  localparam int LCNT_W = 4;
  localparam logic [LEN_W-1:0] SHORT_LEN_RESET = 16'd4800;
  localparam logic [LCNT_W-1:0] LONG_COUNT_RESET = 4'd10;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [0:0] {
    REG_SHORT_WINDOW_LEN  = 1'b0,
    REG_LONG_WINDOW_COUNT = 1'b1
  } reg_idx_t;

  typedef logic [SAMPLE_BITS-1:0] mag_t;
  typedef logic signed [DB_W-1:0] db_t;

  typedef struct packed {
    logic [NORM_W-1:0]   x;
    logic [LOG_FRAC-1:0] frac;
    logic [MSB_W-1:0]    msb;
    logic                zero;
    logic                sat;
  } lane_t;

endpackage

>>> rtl/spmdb_db_conv.sv
// ----------------------------------------------------------------------------
// spmdb_db_conv
// Four-lane magnitude to 1/16 dB converter: normalize, 24 squaring steps for
// the log2 fraction, scale by 320*log10(2), round and clamp
// ----------------------------------------------------------------------------
module spmdb_db_conv (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spmdb_pkg::mag_t   in_mag [spmdb_pkg::LANES],
  input  logic              in_long,
  output logic              out_valid,
  input  logic              out_stall,
  output spmdb_pkg::db_t    out_db [spmdb_pkg::LANES],
  output logic              out_long
);

  logic [spmdb_pkg::PIPE_STAGES-1:0] vld;
  logic [spmdb_pkg::PIPE_STAGES-1:0] en;
  logic [spmdb_pkg::PIPE_STAGES-1:0] lng;

  spmdb_pkg::mag_t mag0 [spmdb_pkg::LANES];

  logic [spmdb_pkg::MSB_W-1:0]   norm_msb [spmdb_pkg::LANES];
  logic [spmdb_pkg::SHIFT_W-1:0] norm_sh  [spmdb_pkg::LANES];
  spmdb_pkg::lane_t              norm_c   [spmdb_pkg::LANES];

  spmdb_pkg::lane_t sq [spmdb_pkg::LOG_FRAC+1][spmdb_pkg::LANES];

  logic [spmdb_pkg::NEG_LOG_W-1:0] neg_log [spmdb_pkg::LANES];
  logic [spmdb_pkg::PROD_W-1:0]    prod_c  [spmdb_pkg::LANES];
  logic [spmdb_pkg::PROD_W-1:0]    prod    [spmdb_pkg::LANES];
  logic [spmdb_pkg::LANES-1:0]     pzero;
  logic [spmdb_pkg::LANES-1:0]     psat;

  logic [spmdb_pkg::PROD_W:0]    rsum [spmdb_pkg::LANES];
  logic [spmdb_pkg::R_W-1:0]     r    [spmdb_pkg::LANES];
  spmdb_pkg::db_t                db_c [spmdb_pkg::LANES];
  spmdb_pkg::db_t                db_q [spmdb_pkg::LANES];

  // a stage loads when the output is not stalled or when it or any stage after it holds a bubble
  for (genvar k = 0; k < spmdb_pkg::PIPE_STAGES; k++) begin : g_en
    assign en[k] = !out_stall || !(&vld[spmdb_pkg::PIPE_STAGES-1:k]);
  end

  assign in_ready  = en[0];
  assign out_valid = vld[spmdb_pkg::ST_OUT];
  assign out_long  = lng[spmdb_pkg::ST_OUT];
  assign out_db    = db_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < spmdb_pkg::PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lng[0] <= in_long;
      mag0   <= in_mag;
    end
    for (int k = 1; k < spmdb_pkg::PIPE_STAGES; k++) begin
      if (en[k]) begin
        lng[k] <= lng[k-1];
      end
    end
  end

  // normalize to a Q31 mantissa in [1,2)
  always_comb begin
    for (int l = 0; l < spmdb_pkg::LANES; l++) begin
      norm_msb[l] = '0;
      for (int b = 0; b < spmdb_pkg::SAMPLE_BITS; b++) begin
        if (mag0[l][b]) begin
          norm_msb[l] = spmdb_pkg::MSB_W'(b);
        end
      end
      norm_sh[l] = spmdb_pkg::SHIFT_W'(spmdb_pkg::NORM_W - 1)
                 - spmdb_pkg::SHIFT_W'(norm_msb[l]);
      norm_c[l].x    = spmdb_pkg::NORM_W'(mag0[l]) << norm_sh[l];
      norm_c[l].frac = '0;
      norm_c[l].msb  = norm_msb[l];
      norm_c[l].zero = (mag0[l] == '0);
      norm_c[l].sat  = (norm_msb[l] >= spmdb_pkg::MSB_W'(spmdb_pkg::SAMPLE_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[spmdb_pkg::ST_NORM]) begin
      sq[0] <= norm_c;
    end
  end

  // one squaring step per stage, one fraction bit each
  for (genvar i = 1; i <= spmdb_pkg::LOG_FRAC; i++) begin : g_sq
    logic [2*spmdb_pkg::NORM_W-1:0] p    [spmdb_pkg::LANES];
    logic [spmdb_pkg::NORM_W:0]     y    [spmdb_pkg::LANES];
    spmdb_pkg::lane_t               sq_c [spmdb_pkg::LANES];

    always_comb begin
      for (int l = 0; l < spmdb_pkg::LANES; l++) begin
        p[l] = sq[i-1][l].x * sq[i-1][l].x;
        y[l] = p[l][2*spmdb_pkg::NORM_W-1:spmdb_pkg::NORM_W-1];
        sq_c[l] = sq[i-1][l];
        if (y[l][spmdb_pkg::NORM_W]) begin
          sq_c[l].x    = y[l][spmdb_pkg::NORM_W:1];
          sq_c[l].frac = {sq[i-1][l].frac[spmdb_pkg::LOG_FRAC-2:0], 1'b1};
        end else begin
          sq_c[l].x    = y[l][spmdb_pkg::NORM_W-1:0];
          sq_c[l].frac = {sq[i-1][l].frac[spmdb_pkg::LOG_FRAC-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[spmdb_pkg::ST_NORM+i]) begin
        sq[i] <= sq_c;
      end
    end
  end

  // negative log2 ratio times dB scale
  always_comb begin
    for (int l = 0; l < spmdb_pkg::LANES; l++) begin
      neg_log[l] = {spmdb_pkg::MSB_W'(spmdb_pkg::SAMPLE_BITS - 1)
                      - sq[spmdb_pkg::LOG_FRAC][l].msb,
                    {spmdb_pkg::LOG_FRAC{1'b0}}}
                 - spmdb_pkg::NEG_LOG_W'(sq[spmdb_pkg::LOG_FRAC][l].frac);
      prod_c[l]  = neg_log[l] * spmdb_pkg::DB_PER_LOG2_Q24;
    end
  end

  always_ff @(posedge clk) begin
    if (en[spmdb_pkg::ST_PROD]) begin
      prod <= prod_c;
      for (int l = 0; l < spmdb_pkg::LANES; l++) begin
        pzero[l] <= sq[spmdb_pkg::LOG_FRAC][l].zero;
        psat[l]  <= sq[spmdb_pkg::LOG_FRAC][l].sat;
      end
    end
  end

  // round to nearest, negate, clamp to floor; zero gives floor, full scale 0, long lanes 0 without long end
  always_comb begin
    for (int l = 0; l < spmdb_pkg::LANES; l++) begin
      rsum[l] = {1'b0, prod[l]}
              + (spmdb_pkg::PROD_W+1)'({1'b1, {(2*spmdb_pkg::LOG_FRAC-1){1'b0}}});
      r[l] = rsum[l][spmdb_pkg::PROD_W:2*spmdb_pkg::LOG_FRAC];
      if (pzero[l]) begin
        db_c[l] = spmdb_pkg::DB_MIN;
      end else if (psat[l]) begin
        db_c[l] = '0;
      end else if (r[l] > spmdb_pkg::R_W'(spmdb_pkg::DB_FLOOR)) begin
        db_c[l] = spmdb_pkg::DB_MIN;
      end else begin
        db_c[l] = '0 - spmdb_pkg::DB_W'(r[l]);
      end
      if (l >= spmdb_pkg::LANE_LONG_L && !lng[spmdb_pkg::ST_PROD]) begin
        db_c[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[spmdb_pkg::ST_OUT]) begin
      db_q <= db_c;
    end
  end

endmodule

>>> rtl/stereo_peak_meter_db_unit.sv
// ----------------------------------------------------------------------------
// stereo_peak_meter_db_unit
// Stereo short and long window peak meter, peaks reported in 1/16 dB
// ----------------------------------------------------------------------------
//  channel  | signals                          | role
//  ---------+----------------------------------+-------------------------------
//  in       | in_valid, in_stall, samples      | one stereo sample pair per item
//  out      | out_valid, out_stall, dB fields  | one item per ended short window
//  config   | psel, penable, pwrite, paddr ... | window length and long count
//
//  one pair accepted per cycle unless stalled; window state updates at acceptance
//  the item that closes its window goes through the input register, normalize,
//  the 24-step squaring pipeline of the log2 unit, scale and round to its result
//  reset (synchronous) clears peaks and counters, restores the window settings
//  in_stall rises only when the closing item finds the dB pipeline full
// ----------------------------------------------------------------------------
module stereo_peak_meter_db_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [spmdb_pkg::ADDR_W-1:0]           paddr,
  input  logic [spmdb_pkg::DATA_W-1:0]           pwdata,
  output logic [spmdb_pkg::DATA_W-1:0]           prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [spmdb_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [spmdb_pkg::SAMPLE_BITS-1:0] right_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [spmdb_pkg::DB_W-1:0]      short_left_db,
  output logic signed [spmdb_pkg::DB_W-1:0]      short_right_db,
  output logic signed [spmdb_pkg::DB_W-1:0]      long_left_db,
  output logic signed [spmdb_pkg::DB_W-1:0]      long_right_db,
  output logic                                   long_valid
);

  logic [spmdb_pkg::LEN_W-1:0]  short_window_len;
  logic [spmdb_pkg::LCNT_W-1:0] long_window_count;
  logic [spmdb_pkg::LEN_W-1:0]  short_sample_count;
  logic [spmdb_pkg::LCNT_W-1:0] long_window_index;
  spmdb_pkg::mag_t              short_peak [2];
  spmdb_pkg::mag_t              long_peak  [2];

  spmdb_pkg::reg_idx_t          reg_sel;
  logic                         cfg_write;
  logic [spmdb_pkg::LEN_W:0]    count_inc;
  logic [spmdb_pkg::LCNT_W:0]   index_inc;
  logic                         short_end;
  logic                         long_end;
  logic                         in_accept;
  spmdb_pkg::mag_t              mag        [2];
  spmdb_pkg::mag_t              short_fold [2];
  spmdb_pkg::mag_t              long_fold  [2];

  logic                         conv_ready;
  spmdb_pkg::mag_t              conv_mag [spmdb_pkg::LANES];
  spmdb_pkg::db_t               conv_db  [spmdb_pkg::LANES];
  logic                         conv_long;

  function automatic spmdb_pkg::mag_t sample_mag(
    input logic signed [spmdb_pkg::SAMPLE_BITS-1:0] s
  );
    return s[spmdb_pkg::SAMPLE_BITS-1] ? spmdb_pkg::mag_t'(~s + 1'b1)
                                       : spmdb_pkg::mag_t'(s);
  endfunction

  // register access
  assign pready    = 1'b1;
  assign reg_sel   = spmdb_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      spmdb_pkg::REG_SHORT_WINDOW_LEN:
        prdata = spmdb_pkg::DATA_W'(short_window_len);
      spmdb_pkg::REG_LONG_WINDOW_COUNT:
        prdata = spmdb_pkg::DATA_W'(long_window_count);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_window_len  <= spmdb_pkg::SHORT_LEN_RESET;
      long_window_count <= spmdb_pkg::LONG_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        spmdb_pkg::REG_SHORT_WINDOW_LEN:
          short_window_len <= pwdata[spmdb_pkg::LEN_W-1:0];
        spmdb_pkg::REG_LONG_WINDOW_COUNT:
          long_window_count <= pwdata[spmdb_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // window bookkeeping and peak folding
  assign count_inc = {1'b0, short_sample_count} + 1'b1;
  assign index_inc = {1'b0, long_window_index} + 1'b1;
  assign short_end = (count_inc >= {1'b0, short_window_len});
  assign long_end  = (index_inc >= {1'b0, long_window_count});
  assign in_stall  = short_end && !conv_ready;
  assign in_accept = in_valid && !in_stall;

  assign mag[0] = sample_mag(left_sample);
  assign mag[1] = sample_mag(right_sample);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      short_fold[c] = (mag[c] > short_peak[c]) ? mag[c] : short_peak[c];
      long_fold[c]  = (mag[c] > long_peak[c])  ? mag[c] : long_peak[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_sample_count <= '0;
      long_window_index  <= '0;
      short_peak         <= '{default: '0};
      long_peak          <= '{default: '0};
    end else if (in_accept) begin
      if (short_end) begin
        short_sample_count <= '0;
        short_peak         <= '{default: '0};
        if (long_end) begin
          long_window_index <= '0;
          long_peak         <= '{default: '0};
        end else begin
          long_window_index <= index_inc[spmdb_pkg::LCNT_W-1:0];
          long_peak         <= long_fold;
        end
      end else begin
        short_sample_count <= count_inc[spmdb_pkg::LEN_W-1:0];
        short_peak         <= short_fold;
        long_peak          <= long_fold;
      end
    end
  end

  assign conv_mag[spmdb_pkg::LANE_SHORT_L] = short_fold[0];
  assign conv_mag[spmdb_pkg::LANE_SHORT_R] = short_fold[1];
  assign conv_mag[spmdb_pkg::LANE_LONG_L]  = long_fold[0];
  assign conv_mag[spmdb_pkg::LANE_LONG_R]  = long_fold[1];

  spmdb_db_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid && short_end),
    .in_ready  (conv_ready),
    .in_mag    (conv_mag),
    .in_long   (long_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_db    (conv_db),
    .out_long  (conv_long)
  );

  assign short_left_db  = conv_db[spmdb_pkg::LANE_SHORT_L];
  assign short_right_db = conv_db[spmdb_pkg::LANE_SHORT_R];
  assign long_left_db   = conv_db[spmdb_pkg::LANE_LONG_L];
  assign long_right_db  = conv_db[spmdb_pkg::LANE_LONG_R];
  assign long_valid     = conv_long;

  a_long_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !long_valid |-> long_left_db == '0 && long_right_db == '0)
    else $error("long peak fields not zero without long window end");

  a_short_db_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> short_left_db <= 0 && short_left_db >= spmdb_pkg::DB_MIN &&
                  short_right_db <= 0 && short_right_db >= spmdb_pkg::DB_MIN)
    else $error("short peak dB out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_accept && !short_end |=> !(&short_sample_count))
    else $error("short sample count reached its top value");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !(&long_window_index))
    else $error("long window index reached its top value");

endmodule

>>> tb/stereo_peak_meter_db_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_peak_meter_db_unit_tb
// Self-checking bench for the stereo short and long window peak meter
// A scoreboard class mirrors the window counters and peak magnitudes and
// works out each dB reading from every accepted sample pair. Readings from
// the block are compared field by field against that queue. Window settings
// go in over the register port between phases. Directed extremes come first,
// then random levels under changing window settings and handshake gaps, plus
// one long receiver hold-off that backs up the sample input.
// ----------------------------------------------------------------------------
module stereo_peak_meter_db_unit_tb;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [spmdb_pkg::SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    spmdb_pkg::db_t short_l;
    spmdb_pkg::db_t short_r;
    spmdb_pkg::db_t long_l;
    spmdb_pkg::db_t long_r;
    logic           long_v;
  } meter_reading_t;

  class peak_meter_scoreboard;
    logic [spmdb_pkg::LEN_W-1:0]  win_len;
    logic [spmdb_pkg::LCNT_W-1:0] win_count;
    logic [spmdb_pkg::LEN_W-1:0]  sample_cnt;
    logic [spmdb_pkg::LCNT_W-1:0] win_idx;
    spmdb_pkg::mag_t              short_pk[2];
    spmdb_pkg::mag_t              long_pk[2];
    meter_reading_t               expected_readings[$];
    int                           mismatch_count;

    function new();
      win_len = spmdb_pkg::SHORT_LEN_RESET;
      win_count = spmdb_pkg::LONG_COUNT_RESET;
      sample_cnt = '0;
      win_idx = '0;
      short_pk[0] = '0;
      short_pk[1] = '0;
      long_pk[0] = '0;
      long_pk[1] = '0;
      mismatch_count = 0;
    endfunction

    function void set_config(spmdb_pkg::reg_idx_t idx,
                             logic [spmdb_pkg::DATA_W-1:0] value);
      case (idx)
        spmdb_pkg::REG_SHORT_WINDOW_LEN:  win_len = value[spmdb_pkg::LEN_W-1:0];
        spmdb_pkg::REG_LONG_WINDOW_COUNT: win_count = value[spmdb_pkg::LCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // 20*log10(m / full scale) in 1/16 dB via fixed-point log2
    function spmdb_pkg::db_t level_db16(spmdb_pkg::mag_t m);
      int                          msb;
      int                          i;
      bit [63:0]                   x;
      bit [63:0]                   neg_log;
      bit [63:0]                   prod;
      bit [63:0]                   r;
      bit [spmdb_pkg::LOG_FRAC-1:0] frac;
      if (m == 0) return spmdb_pkg::DB_MIN;
      msb = 0;
      for (i = 0; i < spmdb_pkg::SAMPLE_BITS; i++) if (m[i]) msb = i;
      x = 64'(m) << (31 - msb);
      frac = '0;
      for (i = 0; i < spmdb_pkg::LOG_FRAC; i++) begin
        x = (x * x) >> 31;
        frac = frac << 1;
        if (x >= 64'h1_0000_0000) begin
          x = x >> 1;
          frac[0] = 1'b1;
        end
      end
      if (msb >= spmdb_pkg::SAMPLE_BITS - 1) return '0;
      neg_log = (64'(spmdb_pkg::SAMPLE_BITS - 1 - msb) << spmdb_pkg::LOG_FRAC)
              - 64'(frac);
      prod = neg_log * 64'(spmdb_pkg::DB_PER_LOG2_Q24);
      r = (prod + (64'd1 << 47)) >> 48;
      if (r > spmdb_pkg::DB_FLOOR) return spmdb_pkg::DB_MIN;
      return spmdb_pkg::db_t'(-int'(r));
    endfunction

    function void record_sample_pair(sample_t left, sample_t right);
      spmdb_pkg::mag_t             m[2];
      bit [spmdb_pkg::LEN_W:0]     next_cnt;
      bit [spmdb_pkg::LCNT_W:0]    next_idx;
      meter_reading_t              rd;
      int                          ch;
      m[0] = left[spmdb_pkg::SAMPLE_BITS-1] ? spmdb_pkg::mag_t'(-left)
                                            : spmdb_pkg::mag_t'(left);
      m[1] = right[spmdb_pkg::SAMPLE_BITS-1] ? spmdb_pkg::mag_t'(-right)
                                             : spmdb_pkg::mag_t'(right);
      for (ch = 0; ch < 2; ch++) begin
        if (m[ch] > short_pk[ch]) short_pk[ch] = m[ch];
        if (m[ch] > long_pk[ch]) long_pk[ch] = m[ch];
      end
      next_cnt = sample_cnt + 1'b1;
      if (next_cnt < win_len) begin
        sample_cnt = next_cnt[spmdb_pkg::LEN_W-1:0];
        return;
      end
      sample_cnt = '0;
      rd.short_l = level_db16(short_pk[0]);
      rd.short_r = level_db16(short_pk[1]);
      short_pk[0] = '0;
      short_pk[1] = '0;
      next_idx = win_idx + 1'b1;
      if (next_idx >= win_count) begin
        win_idx = '0;
        rd.long_l = level_db16(long_pk[0]);
        rd.long_r = level_db16(long_pk[1]);
        rd.long_v = 1'b1;
        long_pk[0] = '0;
        long_pk[1] = '0;
      end else begin
        win_idx = next_idx[spmdb_pkg::LCNT_W-1:0];
        rd.long_l = '0;
        rd.long_r = '0;
        rd.long_v = 1'b0;
      end
      expected_readings.push_back(rd);
    endfunction

    function void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t:%s", $realtime, msg);
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      string          diff;
      if (expected_readings.size() == 0) begin
        note_mismatch($sformatf(" reading with none expected, short %0d/%0d long %0d/%0d v%0b",
                                $signed(got.short_l), $signed(got.short_r),
                                $signed(got.long_l), $signed(got.long_r), got.long_v));
        return;
      end
      want = expected_readings.pop_front();
      diff = "";
      if (got.short_l !== want.short_l)
        diff = {diff, $sformatf(" short_left_db exp %0d got %0d",
                                $signed(want.short_l), $signed(got.short_l))};
      if (got.short_r !== want.short_r)
        diff = {diff, $sformatf(" short_right_db exp %0d got %0d",
                                $signed(want.short_r), $signed(got.short_r))};
      if (got.long_l !== want.long_l)
        diff = {diff, $sformatf(" long_left_db exp %0d got %0d",
                                $signed(want.long_l), $signed(got.long_l))};
      if (got.long_r !== want.long_r)
        diff = {diff, $sformatf(" long_right_db exp %0d got %0d",
                                $signed(want.long_r), $signed(got.long_r))};
      if (got.long_v !== want.long_v)
        diff = {diff, $sformatf(" long_valid exp %0b got %0b", want.long_v, got.long_v)};
      if (diff != "") note_mismatch(diff);
    endfunction

    function int pending_readings();
      return expected_readings.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [spmdb_pkg::ADDR_W-1:0]   paddr;
  logic [spmdb_pkg::DATA_W-1:0]   pwdata;
  logic [spmdb_pkg::DATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  sample_t                        left_sample;
  sample_t                        right_sample;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  spmdb_pkg::db_t                 short_left_db;
  spmdb_pkg::db_t                 short_right_db;
  spmdb_pkg::db_t                 long_left_db;
  spmdb_pkg::db_t                 long_right_db;
  logic                           long_valid;

  peak_meter_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;

  stereo_peak_meter_db_unit uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .short_left_db (short_left_db),
    .short_right_db(short_right_db),
    .long_left_db  (long_left_db),
    .long_right_db (long_right_db),
    .long_valid    (long_valid)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served <= holds_requested;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.record_sample_pair(left_sample, right_sample);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reading(meter_reading_t'{short_left_db, short_right_db, long_left_db,
                                        long_right_db, long_valid});
  end

  function automatic sample_t random_sample();
    logic [spmdb_pkg::SAMPLE_BITS-1:0] v;
    int                                w;
    case ($urandom_range(9))
      0: v = {1'b1, {(spmdb_pkg::SAMPLE_BITS-1){1'b0}}};
      1: v = {1'b0, {(spmdb_pkg::SAMPLE_BITS-1){1'b1}}};
      2: v = '0;
      3, 4: v = spmdb_pkg::SAMPLE_BITS'($urandom);
      default: begin
        w = $urandom_range(spmdb_pkg::SAMPLE_BITS - 1);
        v = spmdb_pkg::SAMPLE_BITS'($urandom) & spmdb_pkg::SAMPLE_BITS'((1 << w) - 1);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return sample_t'(v);
  endfunction

  task automatic write_reg(input spmdb_pkg::reg_idx_t idx,
                           input logic [spmdb_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= spmdb_pkg::ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_config(idx, value);
    @(posedge clk);
  endtask

  task automatic send_pair(input sample_t left, input sample_t right);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_sample <= left;
    right_sample <= right;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_readings() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_windows(input int len, input int count, input int n_items);
    settle();
    write_reg(spmdb_pkg::REG_SHORT_WINDOW_LEN, spmdb_pkg::DATA_W'(len));
    write_reg(spmdb_pkg::REG_LONG_WINDOW_COUNT, spmdb_pkg::DATA_W'(count));
    repeat (n_items) send_pair(random_sample(), random_sample());
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    left_sample <= '0;
    right_sample <= '0;
    tx_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every sample closes a window, so each level is seen directly
    run_windows(1, 3, 0);
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd8388607, -24'sd8388608);
    send_pair(-24'sd1, 24'sd1);
    send_pair(24'sd265271, 24'sd265272);
    send_pair(24'sd265000, -24'sd266000);
    send_pair(24'sd4194304, -24'sd4194304);
    send_pair(24'sd2, 24'sd3);
    send_pair(24'sh555555, 24'shAAAAAA);
    send_pair(24'shAAAAAA, 24'sh555555);
    send_pair(-24'sd8388608, 24'sd8388607);
    send_pair(24'sd8388606, -24'sd8388607);
    send_pair(24'sd1048575, 24'sd1048576);
    send_pair(24'sd838861, -24'sd2652);
    send_pair(24'sd0, 24'sd7);
    send_pair(24'sd5931642, 24'sd2965821);
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd0, 24'sd0);

    // receiver holds off while samples keep coming
    run_windows(1, 2, 0);
    holds_requested <= holds_requested + 1;
    repeat (150) send_pair(random_sample(), random_sample());

    settle();
    tx_idle_pct = 28;
    rx_idle_pct <= 69;
    run_windows(0, 0, 150);
    run_windows(2, 15, 200);
    run_windows(5, 1, 150);

    settle();
    tx_idle_pct = 69;
    rx_idle_pct <= 28;
    run_windows(3, 4, 250);
    run_windows(65535, 7, 300);
    // window left open above, shortened length closes it on the next sample
    run_windows(4, 5, 200);
    run_windows(7, 2, 250);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_windows(1, 15, 200);
    run_windows(64, 1, 128);
    run_windows(6, 3, 200);

    settle();
    if (sb.mismatch_count == 0 && sb.pending_readings() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
